@@ sv/vpr_pkg.sv @@
`default_nettype none
package vpr_pkg;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_SHIFT_BACK = 2'd0,
        CFG_OFFSET_L   = 2'd1,
        CFG_OFFSET_M   = 2'd2,
        CFG_UVW_ONLY   = 2'd3
    } cfg_idx_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic        shift_back_enable;
        logic [30:0] offset_l;
        logic [30:0] offset_m;
        logic        uvw_only;
    } cfg_t;

    localparam int CFG_DATA_BITS = 31;
    localparam int CORDIC_STEPS  = 24;

    // cordic start vector, 1/K in Q2.30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    // path modulus is 125 * 2^33; the upper part is reduced mod 125
    localparam logic [6:0]  MOD_FACTOR = 7'd125;
    // 2^38 / 125 rounded up, exact quotient for any 31-bit dividend
    localparam logic [31:0] DIV125_MUL = 32'd2199023256;
    // multiple of 125 that lifts a signed 16-bit value above zero
    localparam logic signed [17:0] MOD_LIFT = 18'sd32875;
    // half of the modulus, 125 * 2^32
    localparam logic [39:0] HALF_MOD = 40'd536870912000;

    // quotient of n / 125 by reciprocal multiplication
    function automatic logic [24:0] div125(input logic [30:0] n);
        logic [62:0] prod;
        prod = 63'(n) * 63'(DIV125_MUL);
        return prod[62:38];
    endfunction

    // atan(2^-i) in Q32 turns
    function automatic logic signed [31:0] atan_q32(input int unsigned i);
        logic signed [31:0] a;
        case (i)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458908;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10431;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            20:      a = 32'sd652;
            21:      a = 32'sd326;
            22:      a = 32'sd163;
            23:      a = 32'sd81;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

@@ sv/vpr_phase.sv @@
`default_nettype none
module vpr_phase #(
    parameter int SAMPLE_BITS = 24,
    parameter int PHASE_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  vpr_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] vis_re,
    input  logic signed [SAMPLE_BITS-1:0] vis_im,
    input  logic signed [31:0]            new_w,
    input  logic signed [31:0]            old_w,
    input  logic signed [31:0]            new_u,
    input  logic signed [31:0]            new_v,
    input  logic [23:0]                   inv_wavelength,
    output logic                          ph_valid,
    output logic [PHASE_BITS-1:0]         ph_k,
    output logic signed [SAMPLE_BITS-1:0] ph_re,
    output logic signed [SAMPLE_BITS-1:0] ph_im
);
    import vpr_pkg::*;

    localparam int STAGES = 10;
    localparam int GW     = 34 + PHASE_BITS;

    logic [STAGES-1:0]             valid_reg;
    logic signed [SAMPLE_BITS-1:0] re_reg [STAGES];
    logic signed [SAMPLE_BITS-1:0] im_reg [STAGES];

    // stage registers
    logic signed [32:0] dw1_reg;
    logic signed [62:0] pu1_reg, pv1_reg;
    logic [23:0]        inv1_reg, inv2_reg, inv3_reg, inv4_reg;
    logic signed [48:0] d2_reg;
    logic [16:0]        x3_reg;
    logic [9:0]         q3_reg;
    logic [32:0]        low3_reg, low4_reg;
    logic [6:0]         a4_reg;
    logic [56:0]        l5_reg;
    logic [30:0]        ai5_reg;
    logic [30:0]        h6_reg, h7_reg;
    logic [32:0]        g6_reg, g7_reg, g8_reg;
    logic [24:0]        qh7_reg;
    logic [6:0]         b8_reg;
    logic [30:0]        t9_reg;
    logic [PHASE_BITS-1:0] k10_reg;

    // next values
    logic signed [32:0] dw1_next;
    logic signed [62:0] pu1_next, pv1_next;
    logic signed [63:0] sum2;
    logic signed [48:0] d2_next;
    logic signed [49:0] p3;
    logic signed [17:0] xs3;
    logic [16:0]        x3_next;
    logic [24:0]        q3_full;
    logic [6:0]         a4_next;
    logic [56:0]        l5_next;
    logic [30:0]        ai5_next;
    logic [30:0]        h6_next;
    logic [24:0]        qh7_next;
    logic [6:0]         b8_next;
    logic [GW-1:0]      gs9;
    logic [30:0]        t9_next;
    logic [24:0]        qt10;

    // path difference and direction cosine products
    assign dw1_next = 33'(new_w) - 33'(old_w);
    assign pu1_next = 63'(new_u) * 63'($signed(cfg.offset_l));
    assign pv1_next = 63'(new_v) * 63'($signed(cfg.offset_m));

    // total delay in Q.14 mm
    assign sum2    = 64'(pu1_reg) + 64'(pv1_reg);
    assign d2_next = (49'(dw1_reg) <<< 14)
                   + (cfg.shift_back_enable ? 49'(sum2 >>> 16) : 49'sd0);

    // negate, lift the upper part above zero, divide it by 125
    assign p3      = -50'(d2_reg);
    assign xs3     = 18'($signed(p3[49:33])) + MOD_LIFT;
    assign x3_next = xs3[16:0];
    assign q3_full = div125(31'(x3_next));

    // upper part mod 125
    assign a4_next = 7'(x3_reg - 17'(q3_reg) * 17'(MOD_FACTOR));

    // product with inverse wavelength, split at bit 33
    assign l5_next  = 57'(low4_reg) * 57'(inv4_reg);
    assign ai5_next = 31'(a4_reg) * 31'(inv4_reg);

    assign h6_next  = ai5_reg + 31'(l5_reg[56:33]);
    assign qh7_next = div125(h6_reg);
    assign b8_next  = 7'(h7_reg - 31'(qh7_reg) * 31'(MOD_FACTOR));

    // scale to phase bits and add half a step
    assign gs9     = (GW'(g8_reg) << PHASE_BITS) + GW'(HALF_MOD);
    assign t9_next = (31'(b8_reg) << PHASE_BITS) + 31'(gs9 >> 33);
    assign qt10    = div125(t9_reg);

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg[0] <= vis_re;
            im_reg[0] <= vis_im;
            for (int i = 1; i < STAGES; i++)
            begin
                re_reg[i] <= re_reg[i-1];
                im_reg[i] <= im_reg[i-1];
            end
            dw1_reg  <= dw1_next;
            pu1_reg  <= pu1_next;
            pv1_reg  <= pv1_next;
            inv1_reg <= inv_wavelength;
            d2_reg   <= d2_next;
            inv2_reg <= inv1_reg;
            x3_reg   <= x3_next;
            q3_reg   <= q3_full[9:0];
            low3_reg <= p3[32:0];
            inv3_reg <= inv2_reg;
            a4_reg   <= a4_next;
            low4_reg <= low3_reg;
            inv4_reg <= inv3_reg;
            l5_reg   <= l5_next;
            ai5_reg  <= ai5_next;
            h6_reg   <= h6_next;
            g6_reg   <= l5_reg[32:0];
            qh7_reg  <= qh7_next;
            h7_reg   <= h6_reg;
            g7_reg   <= g6_reg;
            b8_reg   <= b8_next;
            g8_reg   <= g7_reg;
            t9_reg   <= t9_next;
            k10_reg  <= qt10[PHASE_BITS-1:0];
        end
    end

    assign ph_valid = valid_reg[STAGES-1];
    assign ph_k     = k10_reg;
    assign ph_re    = re_reg[STAGES-1];
    assign ph_im    = im_reg[STAGES-1];

endmodule
`default_nettype wire

@@ sv/vpr_cordic.sv @@
`default_nettype none
module vpr_cordic #(
    parameter int SAMPLE_BITS = 24,
    parameter int PHASE_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [PHASE_BITS-1:0]         in_k,
    input  logic signed [SAMPLE_BITS-1:0] in_re,
    input  logic signed [SAMPLE_BITS-1:0] in_im,
    output logic                          cor_valid,
    output logic [1:0]                    cor_quad,
    output logic signed [31:0]            cor_x,
    output logic signed [31:0]            cor_y,
    output logic signed [SAMPLE_BITS-1:0] cor_re,
    output logic signed [SAMPLE_BITS-1:0] cor_im
);
    import vpr_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic [N:0]                    valid_reg;
    logic signed [31:0]            x_reg [N+1];
    logic signed [31:0]            y_reg [N+1];
    logic signed [31:0]            z_reg [N+1];
    logic [1:0]                    quad_reg [N+1];
    logic signed [SAMPLE_BITS-1:0] re_reg [N+1];
    logic signed [SAMPLE_BITS-1:0] im_reg [N+1];

    logic signed [31:0] x_next [N+1];
    logic signed [31:0] y_next [N+1];
    logic signed [31:0] z_next [N+1];
    logic [31:0]        ang;

    // angle in Q32 turns, quadrant split off
    assign ang       = 32'(in_k) << (32 - PHASE_BITS);
    assign x_next[0] = GAIN_Q30;
    assign y_next[0] = 32'sd0;
    assign z_next[0] = $signed({2'b00, ang[29:0]});

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_comb
        begin
            if (!z_reg[i][31])
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - atan_q32(i);
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + atan_q32(i);
            end
        end
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[N-1:0], in_valid};
        end
    end

    // rotation and side-band registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quad_reg[0] <= ang[31:30];
            re_reg[0]   <= in_re;
            im_reg[0]   <= in_im;
            for (int i = 0; i <= N; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
            for (int i = 1; i <= N; i++)
            begin
                quad_reg[i] <= quad_reg[i-1];
                re_reg[i]   <= re_reg[i-1];
                im_reg[i]   <= im_reg[i-1];
            end
        end
    end

    assign cor_valid = valid_reg[N];
    assign cor_quad  = quad_reg[N];
    assign cor_x     = x_reg[N];
    assign cor_y     = y_reg[N];
    assign cor_re    = re_reg[N];
    assign cor_im    = im_reg[N];

endmodule
`default_nettype wire

@@ sv/vpr_cmul.sv @@
`default_nettype none
module vpr_cmul #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  vpr_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    input  logic [1:0]                    in_quad,
    input  logic signed [31:0]            in_x,
    input  logic signed [31:0]            in_y,
    input  logic signed [SAMPLE_BITS-1:0] in_re,
    input  logic signed [SAMPLE_BITS-1:0] in_im,
    output logic                          res_valid,
    output logic signed [SAMPLE_BITS-1:0] res_re,
    output logic signed [SAMPLE_BITS-1:0] res_im
);
    import vpr_pkg::*;

    localparam int PW = SAMPLE_BITS + 32;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] SAT_HI =
        $signed({{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [SW-1:0] RND    = SW'(64'sd536870912);

    logic [2:0]                    valid_reg;
    logic signed [SAMPLE_BITS-1:0] re1_reg, im1_reg, re2_reg, im2_reg;
    logic signed [PW-1:0]          rc_reg, is_reg, rs_reg, ic_reg;
    logic signed [SW-1:0]          acc_re_reg, acc_im_reg;
    logic signed [SAMPLE_BITS-1:0] out_re_reg, out_im_reg;

    logic signed [31:0]            c, s;
    logic signed [SW-1:0]          sh_re, sh_im;
    logic signed [SAMPLE_BITS-1:0] out_re_next, out_im_next;

    // quadrant symmetry
    always_comb
    begin
        case (in_quad)
            2'd0:    begin c = in_x;  s = in_y;  end
            2'd1:    begin c = -in_y; s = in_x;  end
            2'd2:    begin c = -in_x; s = -in_y; end
            default: begin c = in_y;  s = -in_x; end
        endcase
    end

    // round half up at bit 30, then saturate
    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[SAMPLE_BITS-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[SAMPLE_BITS-1:0];
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

    assign sh_re = (acc_re_reg + RND) >>> 30;
    assign sh_im = (acc_im_reg + RND) >>> 30;

    // pass-through mode keeps the input word
    assign out_re_next = cfg.uvw_only ? re2_reg : sat(sh_re);
    assign out_im_next = cfg.uvw_only ? im2_reg : sat(sh_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // products, sums, rounded result
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rc_reg     <= PW'(in_re) * PW'(c);
            is_reg     <= PW'(in_im) * PW'(s);
            rs_reg     <= PW'(in_re) * PW'(s);
            ic_reg     <= PW'(in_im) * PW'(c);
            re1_reg    <= in_re;
            im1_reg    <= in_im;
            acc_re_reg <= SW'(rc_reg) - SW'(is_reg);
            acc_im_reg <= SW'(rs_reg) + SW'(ic_reg);
            re2_reg    <= re1_reg;
            im2_reg    <= im1_reg;
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
        end
    end

    assign res_valid = valid_reg[2];
    assign res_re    = out_re_reg;
    assign res_im    = out_im_reg;

endmodule
`default_nettype wire

@@ sv/vpr_outbuf.sv @@
`default_nettype none
module vpr_outbuf #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] in_re,
    input  logic signed [SAMPLE_BITS-1:0] in_im,
    output logic                          adv,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_re,
    output logic signed [SAMPLE_BITS-1:0] out_im
);
    logic [1:0]                    count_reg, count_next;
    logic                          wr_ptr_reg, rd_ptr_reg;
    logic signed [SAMPLE_BITS-1:0] buf_re_reg [2];
    logic signed [SAMPLE_BITS-1:0] buf_im_reg [2];
    logic                          push, pop;

    // pipeline moves while a slot is free
    assign adv       = (count_reg != 2'd2);
    assign push      = adv & in_valid;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (!push && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    // word slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_re_reg[wr_ptr_reg] <= in_re;
            buf_im_reg[wr_ptr_reg] <= in_im;
        end
    end

    assign out_re = buf_re_reg[rd_ptr_reg];
    assign out_im = buf_im_reg[rd_ptr_reg];

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("outbuf count out of range");
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !out_ready) |=> count_reg == 2'd2)
        else $error("outbuf lost a word while full");
    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_re) && $stable(out_im)))
        else $error("outbuf head word changed while stalled");
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("outbuf pointers disagree with count");

endmodule
`default_nettype wire

@@ sv/visibility_phase_rotator.sv @@
`default_nettype none
// channel  dir  handshake            payload
// cfg      in   cfg_we               cfg_index, cfg_data
// in       in   in_valid/in_ready    vis_re, vis_im, new_w, old_w, new_u, new_v, inv_wavelength
// out      out  out_valid/out_ready  out_re, out_im
//
// one word per clock while the output buffer has a free slot; an accepted word passes
// 10 phase-reduction, 25 cordic and 3 multiply/round stages, then the output slot
// reset clears valid bits, buffer fill and config registers, not the data path
// a two-word output buffer keeps taking words after out_ready drops until both slots
// are full, then the whole pipeline holds; in_ready follows the buffer fill only
module visibility_phase_rotator #(
    parameter int SAMPLE_BITS = 24,
    parameter int PHASE_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [30:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] vis_re,
    input  logic signed [SAMPLE_BITS-1:0] vis_im,
    input  logic signed [31:0]            new_w,
    input  logic signed [31:0]            old_w,
    input  logic signed [31:0]            new_u,
    input  logic signed [31:0]            new_v,
    input  logic [23:0]                   inv_wavelength,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_re,
    output logic signed [SAMPLE_BITS-1:0] out_im
);
    import vpr_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic adv;

    logic                          ph_valid;
    logic [PHASE_BITS-1:0]         ph_k;
    logic signed [SAMPLE_BITS-1:0] ph_re, ph_im;
    logic                          cor_valid;
    logic [1:0]                    cor_quad;
    logic signed [31:0]            cor_x, cor_y;
    logic signed [SAMPLE_BITS-1:0] cor_re, cor_im;
    logic                          res_valid;
    logic signed [SAMPLE_BITS-1:0] res_re, res_im;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SHIFT_BACK: cfg_next.shift_back_enable = cfg_data[0];
                CFG_OFFSET_L:   cfg_next.offset_l          = cfg_data[CFG_DATA_BITS-1:0];
                CFG_OFFSET_M:   cfg_next.offset_m          = cfg_data[CFG_DATA_BITS-1:0];
                CFG_UVW_ONLY:   cfg_next.uvw_only          = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign in_ready = adv;

    vpr_phase #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .cfg           (cfg_reg),
        .in_valid      (in_valid & adv),
        .vis_re        (vis_re),
        .vis_im        (vis_im),
        .new_w         (new_w),
        .old_w         (old_w),
        .new_u         (new_u),
        .new_v         (new_v),
        .inv_wavelength(inv_wavelength),
        .ph_valid      (ph_valid),
        .ph_k          (ph_k),
        .ph_re         (ph_re),
        .ph_im         (ph_im)
    );

    vpr_cordic #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (ph_valid),
        .in_k     (ph_k),
        .in_re    (ph_re),
        .in_im    (ph_im),
        .cor_valid(cor_valid),
        .cor_quad (cor_quad),
        .cor_x    (cor_x),
        .cor_y    (cor_y),
        .cor_re   (cor_re),
        .cor_im   (cor_im)
    );

    vpr_cmul #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cmul (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg_reg),
        .in_valid (cor_valid),
        .in_quad  (cor_quad),
        .in_x     (cor_x),
        .in_y     (cor_y),
        .in_re    (cor_re),
        .in_im    (cor_im),
        .res_valid(res_valid),
        .res_re   (res_re),
        .res_im   (res_im)
    );

    vpr_outbuf #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_re    (res_re),
        .in_im    (res_im),
        .adv      (adv),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_re   (out_re),
        .out_im   (out_im)
    );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
    import vpr_pkg::*;

    localparam longint RUN_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 60;

    // fixed-point rotation of one sample with its own register copy
    class rotation_scoreboard;
        bit                 shift_back;
        logic signed [30:0] dl;
        logic signed [30:0] dm;
        bit                 pass_through;
        logic signed [23:0] want_re[$];
        logic signed [23:0] want_im[$];
        int                 errors;

        function void set_reg(cfg_idx_t idx, logic [30:0] value);
            case (idx)
                CFG_SHIFT_BACK: shift_back = value[0];
                CFG_OFFSET_L:   dl = value;
                CFG_OFFSET_M:   dm = value;
                CFG_UVW_ONLY:   pass_through = value[0];
                default: ;
            endcase
        endfunction

        function longint round_clip(longint acc);
            longint r;
            r = (acc + (longint'(1) <<< 29)) >>> 30;
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            return r;
        endfunction

        // work out the rotated sample for one accepted word
        function void note_sample(logic signed [23:0] vr, logic signed [23:0] vi,
                                  logic signed [31:0] nw, logic signed [31:0] ow,
                                  logic signed [31:0] nu, logic signed [31:0] nv,
                                  logic [23:0] inv);
            longint atan_turns[24] = '{536870912, 316933406, 167458908, 85004756,
                42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                333772, 166886, 83443, 41722, 20861, 10431, 5215, 2608, 1304, 652,
                326, 163, 81};
            longint path_mod;
            longint d, p, x, y, z, dx, dy, c, s;
            longint unsigned r, f, k;
            logic [31:0] ang;
            path_mod = longint'(1000) <<< 30;
            if (pass_through) begin
                want_re.push_back(vr);
                want_im.push_back(vi);
                return;
            end
            // path difference in Q.14 mm
            d = (longint'(nw) - longint'(ow)) * 16384;
            if (shift_back)
                d += (longint'(nu) * longint'(dl) + longint'(nv) * longint'(dm)) >>> 16;
            p = (-d) % path_mod;
            if (p < 0) p += path_mod;
            r = p;
            f = (r * longint'(inv)) % path_mod;
            k = ((f << 16) + (path_mod >> 1)) / path_mod;
            ang = {k[15:0], 16'h0};
            // cordic on the in-quadrant remainder
            x = GAIN_Q30;
            y = 0;
            z = longint'(ang[29:0]);
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_turns[i];
                end
                else begin
                    x += dx; y -= dy; z += atan_turns[i];
                end
            end
            case (ang[31:30])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            want_re.push_back(24'(round_clip(longint'(vr) * c - longint'(vi) * s)));
            want_im.push_back(24'(round_clip(longint'(vr) * s + longint'(vi) * c)));
        endfunction

        function void check_sample(logic signed [23:0] re, logic signed [23:0] im);
            logic signed [23:0] er, ei;
            if (want_re.size() == 0) begin
                $error("unexpected word out_re=%0d out_im=%0d", re, im);
                errors++;
                return;
            end
            er = want_re.pop_front();
            ei = want_im.pop_front();
            if (re !== er) begin
                $error("out_re expected %0d got %0d", er, re);
                errors++;
            end
            if (im !== ei) begin
                $error("out_im expected %0d got %0d", ei, im);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [23:0] vis_re = '0, vis_im = '0;
    logic signed [31:0] new_w = '0, old_w = '0, new_u = '0, new_v = '0;
    logic [23:0] inv_wavelength = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [23:0] out_re, out_im;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off = 1'b0;
    longint cycles = 0;
    rotation_scoreboard sb = new();

    visibility_phase_rotator dut (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver with random stalls and a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // check every accepted word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_sample(out_re, out_im);
    end

    task automatic write_reg(cfg_idx_t idx, logic [30:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic set_all(bit en, logic [30:0] l, logic [30:0] m, bit uvw);
        write_reg(CFG_SHIFT_BACK, 31'(en));
        write_reg(CFG_OFFSET_L, l);
        write_reg(CFG_OFFSET_M, m);
        write_reg(CFG_UVW_ONLY, 31'(uvw));
    endtask

    // stop offering and wait until every word is out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.want_re.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // offer one word and wait for it to be taken
    task automatic send_sample(logic [23:0] vr, logic [23:0] vi, logic [31:0] nw,
                               logic [31:0] ow, logic [31:0] nu, logic [31:0] nv,
                               logic [23:0] inv);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vis_re <= vr;
        vis_im <= vi;
        new_w <= nw;
        old_w <= ow;
        new_u <= nu;
        new_v <= nv;
        inv_wavelength <= inv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_sample(vr, vi, nw, ow, nu, nv, inv);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(200000)) - 100000);
            2: return 32'($signed($urandom_range(20000000)) - 10000000);
            default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    task automatic send_random();
        logic [23:0] vr, vi, inv;
        logic [31:0] nw, ow;
        vr = $urandom;
        vi = $urandom;
        if ($urandom_range(9) == 0) vr = $urandom_range(1) ? 24'h7fffff : 24'h800000;
        if ($urandom_range(9) == 0) vi = $urandom_range(1) ? 24'h7fffff : 24'h800000;
        case ($urandom_range(5))
            0: inv = 24'd0;
            1: inv = 24'hffffff;
            default: inv = $urandom;
        endcase
        nw = rand_coord();
        ow = ($urandom_range(7) == 0) ? nw : rand_coord();
        send_sample(vr, vi, nw, ow, rand_coord(), rand_coord(), inv);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, then extremes
        send_sample(24'h7fffff, 24'h7fffff, 0, 0, 0, 0, 0);
        send_sample(24'h800000, 24'h800000, 0, 0, 0, 0, 24'hffffff);
        send_sample(24'h7fffff, 24'h800000, 32'h7fffffff, 32'h80000000, 0, 0, 24'hffffff);
        send_sample(24'h800000, 24'h7fffff, 32'h80000000, 32'h7fffffff, 0, 0, 24'h010000);
        send_sample(24'd1000, -24'sd1000, 250, 0, 0, 0, 24'h010000);
        send_sample(24'd1000, 24'd1000, 500, 0, 0, 0, 24'h010000);
        send_sample(24'd1000, 24'd1000, 1000, 0, 0, 0, 24'h010000);
        send_sample(24'd12345, 24'd54321, 777, 777, 32'h7fffffff, 32'h80000000, 24'h123456);
        send_sample(24'h7fffff, 24'h7fffff, 125, 0, 0, 0, 24'h010000);
        drain();
        set_all(1'b1, 31'h3fffffff, 31'h40000000, 1'b0);
        send_sample(24'h7fffff, 24'h800000, 0, 0, 32'h7fffffff, 32'h7fffffff, 24'hffffff);
        send_sample(24'h800000, 24'h7fffff, 0, 0, 32'h80000000, 32'h80000000, 24'hffffff);
        send_sample(24'd4000, 24'd3000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                    32'h7fffffff, 24'hffffff);
        send_sample(24'd77, 24'd88, 10, 10, 1000, 1000, 0);
        drain();
        set_all(1'b0, 31'h40000000, 31'h3fffffff, 1'b1);
        send_sample(24'h7fffff, 24'h800000, 5, 9, 1, 2, 24'hffffff);
        send_sample(24'h800000, 24'h7fffff, $urandom, $urandom, $urandom, $urandom, $urandom);

        // random phases across settings and idling modes
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            case (ph)
                0: set_all(1'b0, 31'h0, 31'h0, 1'b0);
                3: set_all(1'b1, 31'h40000000, 31'h40000000, 1'b0);
                6: set_all(1'b1, 31'h3fffffff, 31'h3fffffff, 1'b0);
                7: set_all($urandom_range(1), $urandom, $urandom, 1'b1);
                default: set_all(1'b1, $urandom, $urandom, 1'b0);
            endcase
            if (ph == 4)
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            for (int n = 0; n < 104; n++)
                send_random();
        end
        drain();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
